/* rtl/if0rt_pkg.sv */
// Shared types, character codes and helpers for the #if 0 region tracker.
`default_nettype none
package if0rt_pkg;

  localparam int unsigned HIST = 6;
  localparam int unsigned CW   = 16;
  localparam int unsigned UCW  = 3;

  typedef logic [CW-1:0]       unit_t;
  typedef logic [HIST:0][CW-1:0] win_t;   // [0] newest unit
  typedef logic [UCW-1:0]      ucnt_t;

  localparam ucnt_t CNT_MAX = 3'd7;

  localparam unit_t CH_HASH  = 16'h0023;
  localparam unit_t CH_SPACE = 16'h0020;
  localparam unit_t CH_TAB   = 16'h0009;
  localparam unit_t CH_ZERO  = 16'h0030;
  localparam unit_t CH_SLASH = 16'h002F;
  localparam unit_t CH_STAR  = 16'h002A;
  localparam unit_t CH_UA    = 16'h0041;
  localparam unit_t CH_UZ    = 16'h005A;
  localparam unit_t CH_D     = 16'h0064;
  localparam unit_t CH_E     = 16'h0065;
  localparam unit_t CH_F     = 16'h0066;
  localparam unit_t CH_I     = 16'h0069;
  localparam unit_t CH_L     = 16'h006C;
  localparam unit_t CH_N     = 16'h006E;
  localparam unit_t CH_S     = 16'h0073;

  localparam unit_t CASE_OFS = 16'h0020;

  typedef struct packed {
    logic if0;          // #if 0
    logic nest_open;    // #if<sp>, #if<tab>, #ifdef, #ifndef
    logic endif_kw;     // #endif
    logic else_kw;      // #else, #elif
    logic dslash;       // //
    logic cmt_open;     // /*
    logic cmt_close;    // */
  } match_t;

  function automatic unit_t fold(input unit_t c);
    unit_t r;
    r = c;
    if (c >= CH_UA && c <= CH_UZ) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/if0rt_match.sv */
// Keyword and comment-marker detection over the recent code-unit window.
`default_nettype none
module if0rt_match (
  input  var if0rt_pkg::win_t   win,
  input  var if0rt_pkg::ucnt_t  cnt,
  output var if0rt_pkg::match_t m
);
  import if0rt_pkg::*;

  unit_t f [HIST+1];
  logic  if_pfx;
  logic  ge2, ge4, ge5, ge6, ge7;

  always_comb begin
    for (int k = 0; k <= HIST; k++) begin
      f[k] = fold(win[k]);
    end
  end

  assign ge2 = (cnt >= 3'd2);
  assign ge4 = (cnt >= 3'd4);
  assign ge5 = (cnt >= 3'd5);
  assign ge6 = (cnt >= 3'd6);
  assign ge7 = (cnt >= 3'd7);

  // "#if" ending one unit before the newest
  assign if_pfx = (f[3] == CH_HASH) && (f[2] == CH_I) && (f[1] == CH_F);

  always_comb begin
    m.if0 = ge5 && (f[4] == CH_HASH) && (f[3] == CH_I) && (f[2] == CH_F)
            && (f[1] == CH_SPACE) && (f[0] == CH_ZERO);
    m.nest_open =
        (ge4 && if_pfx && ((f[0] == CH_SPACE) || (f[0] == CH_TAB)))
      || (ge6 && (f[5] == CH_HASH) && (f[4] == CH_I) && (f[3] == CH_F)
          && (f[2] == CH_D) && (f[1] == CH_E) && (f[0] == CH_F))
      || (ge7 && (f[6] == CH_HASH) && (f[5] == CH_I) && (f[4] == CH_F)
          && (f[3] == CH_N) && (f[2] == CH_D) && (f[1] == CH_E) && (f[0] == CH_F));
    m.endif_kw = ge6 && (f[5] == CH_HASH) && (f[4] == CH_E) && (f[3] == CH_N)
                 && (f[2] == CH_D) && (f[1] == CH_I) && (f[0] == CH_F);
    m.else_kw = ge5 && (f[4] == CH_HASH) && (f[3] == CH_E) && (f[2] == CH_L)
                && (((f[1] == CH_S) && (f[0] == CH_E))
                 || ((f[1] == CH_I) && (f[0] == CH_F)));
    m.dslash    = ge2 && (win[1] == CH_SLASH) && (win[0] == CH_SLASH);
    m.cmt_open  = ge2 && (win[1] == CH_SLASH) && (win[0] == CH_STAR);
    m.cmt_close = ge2 && (win[1] == CH_STAR)  && (win[0] == CH_SLASH);
  end

endmodule
`default_nettype wire

/* rtl/if0_region_tracker_core.sv */
// Top level: #if 0 region tracker with stream input, result register and enable register.
// An accepted input word is held in the input register; its result word is then registered in the result register.
// Throughput: one word per cycle while the output is not stalled; each word's state update is one pass between
// the input register and the result register.
// Reset (rst_n low, synchronous): region closed, level zero, comment and line
// state cleared, pipeline empty, enable set to one.
`default_nettype none
module if0_region_tracker_core #(
  parameter int unsigned MAX_NEST = 255
) (
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic        in_tvalid,
  output var logic        in_tready,
  input  var logic [15:0] in_tdata,   // [15:0] code_unit
  input  var logic        in_tlast,   // last_in_line
  output var logic        out_tvalid,
  input  var logic        out_tready,
  output var logic [15:0] out_tdata,  // [0] in_region, [1] region_start,
                                      // [2] region_end, [10:3] nest_level, [15:11] zero
  input  var logic        cfg_wr_en,
  input  var logic        cfg_wr_data
);
  import if0rt_pkg::*;

  localparam int unsigned DW = $clog2(MAX_NEST + 1);

  logic          s1_valid_r;
  unit_t         s1_unit_r;
  logic          s1_last_r;
  logic          advance, process;

  unit_t         recent_r [HIST];
  win_t          win;
  ucnt_t         units_r, units_nxt, cnt, cnt_nxt;
  logic          region_r, region_nxt;
  logic [DW-1:0] depth_r, depth_nxt, depth_dec;
  logic          bc_r, bc_nxt;
  logic          ign_r, ign_nxt;
  logic          enable_r;
  logic          start_c, end_c;
  match_t        m;

  logic          out_valid_r;
  logic          o_region_r, o_start_r, o_end_r;
  logic [7:0]    o_nest_r;
  logic [DW+7:0] depth_ext;

  assign advance   = !out_valid_r || out_tready;
  assign process   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    win[0] = s1_unit_r;
    for (int k = 0; k < HIST; k++) begin
      win[k+1] = recent_r[k];
    end
  end

  assign cnt = (units_r == CNT_MAX) ? CNT_MAX : units_r + 3'd1;

  if0rt_match u_match (
    .win (win),
    .cnt (cnt),
    .m   (m)
  );

  assign depth_dec = (depth_r != '0) ? depth_r - 1'b1 : depth_r;

  always_comb begin
    region_nxt = region_r;
    depth_nxt  = depth_r;
    bc_nxt     = bc_r;
    ign_nxt    = ign_r;
    cnt_nxt    = cnt;
    start_c    = 1'b0;
    end_c      = 1'b0;
    if (!region_r) begin
      if (enable_r && m.if0) begin
        region_nxt = 1'b1;
        depth_nxt  = DW'(1);
        start_c    = 1'b1;
        cnt_nxt    = '0;
      end
    end else if (!ign_r) begin
      priority if (bc_r) begin
        if (m.cmt_close) begin
          bc_nxt  = 1'b0;
          cnt_nxt = '0;
        end
      end else if (m.dslash) begin
        ign_nxt = 1'b1;
      end else if (m.cmt_open) begin
        bc_nxt  = 1'b1;
        cnt_nxt = '0;
      end else if (m.nest_open) begin
        if (depth_r < DW'(MAX_NEST)) begin
          depth_nxt = depth_r + 1'b1;
        end
      end else if (m.endif_kw) begin
        depth_nxt = depth_dec;
        if (depth_dec == '0) begin
          end_c = 1'b1;
        end
      end else if (m.else_kw) begin
        if (depth_r == DW'(1)) begin
          depth_nxt = '0;
          end_c     = 1'b1;
        end
      end else begin
      end
      if (end_c) begin
        region_nxt = 1'b0;
        depth_nxt  = '0;
        bc_nxt     = 1'b0;
        cnt_nxt    = '0;
      end
    end
    units_nxt = cnt_nxt;
    if (s1_last_r) begin
      units_nxt = '0;
      bc_nxt    = 1'b0;
      ign_nxt   = 1'b0;
    end
  end

  assign depth_ext = {8'h00, depth_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      region_r    <= 1'b0;
      depth_r     <= '0;
      bc_r        <= 1'b0;
      ign_r       <= 1'b0;
      units_r     <= '0;
      enable_r    <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (process) begin
        out_valid_r <= 1'b1;
        region_r    <= region_nxt;
        depth_r     <= depth_nxt;
        bc_r        <= bc_nxt;
        ign_r       <= ign_nxt;
        units_r     <= units_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_unit_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (process) begin
      recent_r[0] <= s1_unit_r;
      for (int k = 1; k < HIST; k++) begin
        recent_r[k] <= recent_r[k-1];
      end
      o_region_r <= region_nxt;
      o_start_r  <= start_c;
      o_end_r    <= end_c;
      o_nest_r   <= depth_ext[7:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, o_nest_r, o_end_r, o_start_r, o_region_r};

  a_region_depth: assert property (@(posedge clk) disable iff (!rst_n)
    region_r == (depth_r != '0))
    else $error("region flag and nest level disagree");

  a_start_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_start_r && o_end_r))
    else $error("region start and end on one word");

  a_start_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_start_r) |-> (o_region_r && o_nest_r == 8'd1))
    else $error("region start without open region at level one");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire
